@@ src/assert_macros.svh @@
// Assertion macros for the range map checker core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, clocked on the rising edge, off during reset.
`define TRMC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define TRMC_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ src/trmc_pkg.sv @@
// Package of types, constants and codes for the tensor range map checker.
package trmc_pkg;

    // Width of address values and of the divisor used for the alignment check.
    localparam int ADDR_BITS      = 64;
    localparam int ALIGN_BITS     = 32;
    localparam int FIELD_BITS     = 64;
    localparam int ALIGN_REG_BITS = 32;
    localparam int DIV_BITS       = (ALIGN_BITS < ALIGN_REG_BITS) ? ALIGN_BITS : ALIGN_REG_BITS;
    localparam int CNT_BITS       = $clog2(ADDR_BITS);
    localparam int CFG_IDX_BITS   = 2;

    typedef logic [ADDR_BITS-1:0] addr_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_FILE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALIGN_BYTES = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DATA_START  = 2'd2;

    // Item modes.
    localparam logic MODE_BEGIN = 1'b0;
    localparam logic MODE_ROW   = 1'b1;

    typedef enum logic [2:0] {
        V_OK         = 3'd0,
        V_MISALIGNED = 3'd1,
        V_WRAPS      = 3'd2,
        V_EXCEEDS    = 3'd3,
        V_TOTAL_OVF  = 3'd4,
        V_SKIPPED    = 3'd5
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CMP_OFF,
        ST_ADD_END,
        ST_CMP_END,
        ST_CHK_SUM,
        ST_FINISH
    } state_t;

    // Configuration as seen by the sequencer.
    typedef struct packed {
        addr_t               file_length;
        logic [DIV_BITS-1:0] align;
        addr_t               data_start;
    } cfg_t;

    // Control to and status from the serial remainder unit.
    typedef struct packed {
        logic start;
    } mod_ctl_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } mod_stat_t;

endpackage

@@ src/trmc_ifs.sv @@
// Valid/ready channel interfaces for input items and result items.
interface trmc_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [63:0] span_offset;
    logic [63:0] span_bytes;

    modport source (output valid, output mode, output span_offset, output span_bytes,
                    input ready);
    modport sink (input valid, input mode, input span_offset, input span_bytes,
                  output ready);
endinterface

interface trmc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic        refused_flag;
    logic [63:0] rows_checked;
    logic [63:0] bytes_total;
    logic [63:0] first_expected;
    logic [63:0] first_available;

    modport source (output valid, output verdict, output refused_flag, output rows_checked,
                    output bytes_total, output first_expected, output first_available,
                    input ready);
    modport sink (input valid, input verdict, input refused_flag, input rows_checked,
                  input bytes_total, input first_expected, input first_available,
                  output ready);
endinterface

@@ src/trmc_mod_unit.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module trmc_mod_unit
    import trmc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  mod_ctl_t            ctl,
    input  addr_t               dividend,
    input  logic [DIV_BITS-1:0] divisor,
    output mod_stat_t           stat
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    addr_t               shift_reg, shift_next;
    logic [DIV_BITS-1:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0] div_reg, div_next;
    logic [DIV_BITS:0]   trial;
    logic [DIV_BITS:0]   diff;

    // One restoring step: bring in the next bit, subtract if it fits.
    assign trial = {rem_reg, shift_reg[ADDR_BITS-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = done_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (ctl.start)
        begin
            // A zero alignment behaves as one.
            div_next   = (divisor == '0) ? DIV_BITS'(1) : divisor;
            rem_next   = '0;
            shift_next = dividend;
            cnt_next   = CNT_BITS'(ADDR_BITS - 1);
            busy_next  = 1'b1;
            done_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next   = diff[DIV_BITS] ? trial[DIV_BITS-1:0] : diff[DIV_BITS-1:0];
            shift_next = {shift_reg[ADDR_BITS-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);

endmodule

@@ src/trmc_core.sv @@
// Sequencer with one shared adder that runs the range checks and keeps the facts.
`include "assert_macros.svh"

module trmc_core
    import trmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    trmc_in_if.sink     req,
    trmc_out_if.source  rsp
);

    state_t              state_reg, state_next;
    verdict_t            verdict_reg, verdict_next;
    logic                mode_reg, mode_next;
    addr_t               off_reg, off_next;
    addr_t               len_reg, len_next;
    addr_t               end_reg, end_next;
    addr_t               sum_reg, sum_next;
    logic [FIELD_BITS-1:0] row_count_reg, row_count_next;
    addr_t               first_exp_reg, first_exp_next;
    addr_t               first_avail_reg, first_avail_next;
    logic                refused_reg, refused_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic                load_out;

    verdict_t              out_verdict_reg;
    logic                  out_refused_reg;
    logic [FIELD_BITS-1:0] out_rows_reg;
    logic [FIELD_BITS-1:0] out_bytes_reg;
    logic [FIELD_BITS-1:0] out_fexp_reg;
    logic [FIELD_BITS-1:0] out_favail_reg;

    mod_ctl_t            mod_ctl;
    mod_stat_t           mod_stat;

    addr_t               alu_a;
    addr_t               alu_b;
    logic                alu_sub;
    logic [ADDR_BITS:0]  alu_res;
    logic                alu_carry;
    addr_t               alu_sum;

    // Serial remainder for the alignment check.
    trmc_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mod_ctl),
        .dividend (off_next),
        .divisor  (cfg.align),
        .stat     (mod_stat)
    );

    // Shared adder: a + b, or a - b with carry meaning no borrow.
    assign alu_res   = {1'b0, alu_a} + {1'b0, alu_b ^ {ADDR_BITS{alu_sub}}}
                       + {{ADDR_BITS{1'b0}}, alu_sub};
    assign alu_carry = alu_res[ADDR_BITS];
    assign alu_sum   = alu_res[ADDR_BITS-1:0];

    // Next state, operand selection and fact updates.
    always_comb
    begin
        state_next       = state_reg;
        verdict_next     = verdict_reg;
        mode_next        = mode_reg;
        off_next         = off_reg;
        len_next         = len_reg;
        end_next         = end_reg;
        sum_next         = sum_reg;
        row_count_next   = row_count_reg;
        first_exp_next   = first_exp_reg;
        first_avail_next = first_avail_reg;
        refused_next     = refused_reg;
        load_out         = 1'b0;
        mod_ctl.start    = 1'b0;
        alu_a            = cfg.file_length;
        alu_b            = off_reg;
        alu_sub          = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next = req.mode;
                    off_next  = (req.mode == MODE_ROW) ? req.span_offset[ADDR_BITS-1:0]
                                                       : cfg.data_start;
                    len_next  = req.span_bytes[ADDR_BITS-1:0];
                    if (req.mode == MODE_BEGIN)
                    begin
                        sum_next         = '0;
                        row_count_next   = '0;
                        first_exp_next   = '0;
                        first_avail_next = '0;
                        refused_next     = 1'b0;
                        mod_ctl.start    = 1'b1;
                        state_next       = ST_MOD;
                    end
                    else if (refused_reg)
                    begin
                        verdict_next = V_SKIPPED;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        mod_ctl.start = 1'b1;
                        state_next    = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                if (mod_stat.done)
                begin
                    if (!mod_stat.rem_zero)
                    begin
                        verdict_next = V_MISALIGNED;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_CMP_OFF;
                    end
                end
            end
            ST_CMP_OFF:
            begin
                // file_length - offset; a borrow means the offset lies past the end.
                alu_a   = cfg.file_length;
                alu_b   = off_reg;
                alu_sub = 1'b1;
                if (!alu_carry)
                begin
                    verdict_next = V_EXCEEDS;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    if (mode_reg == MODE_ROW && row_count_reg == '0)
                    begin
                        first_exp_next   = len_reg;
                        first_avail_next = alu_sum;
                    end
                    if (mode_reg == MODE_BEGIN)
                    begin
                        verdict_next = V_OK;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_ADD_END;
                    end
                end
            end
            ST_ADD_END:
            begin
                // offset + size; a carry out means the range wraps.
                alu_a    = off_reg;
                alu_b    = len_reg;
                alu_sub  = 1'b0;
                end_next = alu_sum;
                if (alu_carry)
                begin
                    verdict_next = V_WRAPS;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    state_next = ST_CMP_END;
                end
            end
            ST_CMP_END:
            begin
                alu_a   = cfg.file_length;
                alu_b   = end_reg;
                alu_sub = 1'b1;
                if (!alu_carry)
                begin
                    verdict_next = V_EXCEEDS;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    state_next = ST_CHK_SUM;
                end
            end
            ST_CHK_SUM:
            begin
                // The running total refuses rather than wrap.
                alu_a   = sum_reg;
                alu_b   = len_reg;
                alu_sub = 1'b0;
                if (alu_carry)
                begin
                    verdict_next = V_TOTAL_OVF;
                end
                else
                begin
                    verdict_next   = V_OK;
                    sum_next       = alu_sum;
                    row_count_next = row_count_reg + FIELD_BITS'(1);
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load_out     = 1'b1;
                    refused_next = refused_reg
                                   || (verdict_reg != V_OK && verdict_reg != V_SKIPPED);
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register handshake.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    // Control state and running facts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rsp_valid_reg   <= 1'b0;
            sum_reg         <= '0;
            row_count_reg   <= '0;
            first_exp_reg   <= '0;
            first_avail_reg <= '0;
            refused_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rsp_valid_reg   <= rsp_valid_next;
            sum_reg         <= sum_next;
            row_count_reg   <= row_count_next;
            first_exp_reg   <= first_exp_next;
            first_avail_reg <= first_avail_next;
            refused_reg     <= refused_next;
        end
    end

    // Item operands and verdict.
    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        mode_reg    <= mode_next;
        off_reg     <= off_next;
        len_reg     <= len_next;
        end_reg     <= end_next;
    end

    // Result payload, captured as the item finishes.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_verdict_reg <= verdict_reg;
            out_refused_reg <= refused_next;
            out_rows_reg    <= row_count_reg;
            out_bytes_reg   <= FIELD_BITS'(sum_reg);
            out_fexp_reg    <= FIELD_BITS'(first_exp_reg);
            out_favail_reg  <= FIELD_BITS'(first_avail_reg);
        end
    end

    assign req.ready           = (state_reg == ST_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.verdict         = out_verdict_reg;
    assign rsp.refused_flag    = out_refused_reg;
    assign rsp.rows_checked    = out_rows_reg;
    assign rsp.bytes_total     = out_bytes_reg;
    assign rsp.first_expected  = out_fexp_reg;
    assign rsp.first_available = out_favail_reg;

    `TRMC_ASSERT(a_start_from_idle, clk, rst_n, mod_ctl.start |-> (state_reg == ST_IDLE), "remainder unit started outside idle")
    `TRMC_ASSERT(a_refuse_at_finish, clk, rst_n, $rose(refused_reg) |-> ($past(state_reg) == ST_FINISH), "refusal set outside the finish step")
    `TRMC_ASSERT(a_row_count_step, clk, rst_n, (row_count_reg != $past(row_count_reg)) |-> ((row_count_reg == $past(row_count_reg) + FIELD_BITS'(1)) || (row_count_reg == '0)), "row count moved by other than one")
    `TRMC_ASSERT(a_skip_is_refused, clk, rst_n, (rsp_valid_reg && out_verdict_reg == V_SKIPPED) |-> out_refused_reg, "skipped row reported without refusal")

endmodule

@@ src/tensor_range_map_checker.sv @@
// A row passes the alignment, offset, wrap, end and total checks in that order and
// stops at the first that fails; a begin item takes only the alignment and offset checks
// on the data start, and a row after a refusal is skipped without any check.
// The bit-serial remainder over the 64-bit offset runs the alignment check.
// One item is in work at a time; the next is taken in the cycle after the result is registered,
// once the previous result has been taken. Reset clears all facts and configuration to zero.
module tensor_range_map_checker
    import trmc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [FIELD_BITS-1:0]   cfg_wdata,
    trmc_in_if.sink                 req,
    trmc_out_if.source              rsp
);

    addr_t               file_length_reg;
    logic [DIV_BITS-1:0] align_reg;
    addr_t               data_start_reg;
    cfg_t                cfg;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
            align_reg       <= '0;
            data_start_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FILE_LENGTH: file_length_reg <= cfg_wdata[ADDR_BITS-1:0];
                CFG_ALIGN_BYTES: align_reg       <= cfg_wdata[DIV_BITS-1:0];
                CFG_DATA_START:  data_start_reg  <= cfg_wdata[ADDR_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.file_length = file_length_reg;
    assign cfg.align       = align_reg;
    assign cfg.data_start  = data_start_reg;

    // Check sequencer.
    trmc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
